[hw/rtl/rmadc_pkg.sv]
// Shared types and constants of the ratiometric ADC averager.
// Depends on nothing; every other file of the block imports it.
package rmadc_pkg;

   localparam int OP_W        = 2;
   localparam int SAMPLE_W    = 12;
   localparam int VCC_W       = 13;
   localparam int AVG_W       = 20;
   localparam int RATIO_AVG_W = 21;
   localparam int COUNT_W     = 8;
   localparam int RAW_SUM_W   = 28;
   localparam int RATIO_SUM_W = 29;
   localparam int PROD_W      = SAMPLE_W + VCC_W;

   localparam int REQ_USER_W  = OP_W;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_USER_W  = 1;
   localparam int RSP_DATA_W  = 64;

   localparam logic [VCC_W-1:0] RAIL_NOMINAL_MV = 13'd5000;
   localparam logic [VCC_W-1:0] RAIL_LOW_MV     = 13'd3000;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_AVG   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      DIV_TERM  = 2'd0,
      DIV_RAW   = 2'd1,
      DIV_RATIO = 2'd2
   } div_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV_TERM,
      ST_ADD,
      ST_DIV_RAW,
      ST_DIV_RATIO,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        add;
      logic        store_raw;
      logic        store_ratio;
      logic        clear;
      logic        emit;
      logic        fresh;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   low_rail;
      logic   count_zero;
      logic   div_done;
   } dp_status_type;

endpackage

[hw/rtl/rmadc_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on rmadc_pkg for the divisor width.
module rmadc_div #(
   parameter int DIV_W = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DIV_W-1:0]           dividend,
   input  logic [rmadc_pkg::VCC_W-1:0] divisor,
   output logic [DIV_W-1:0]           quotient,
   output logic                       done
);
   import rmadc_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [VCC_W-1:0] rem_ff, rem_in;
   logic [VCC_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [VCC_W:0]   shifted;
   logic [VCC_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the difference when it did not go negative
         if (!diff[VCC_W]) begin
            rem_in = diff[VCC_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[VCC_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

[hw/rtl/rmadc_dp.sv]
// Datapath: item registers, sums, count, held averages and result word.
// Depends on rmadc_pkg and rmadc_div.
module rmadc_dp #(
   parameter int FRACTION_BITS = 8,
   parameter int HALVING_COUNT = 254,
   parameter int DIV_W         = 33
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rmadc_pkg::dp_cmd_type           cmd,
   output rmadc_pkg::dp_status_type        status,
   input  logic [rmadc_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic [rmadc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic [rmadc_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic [rmadc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rmadc_pkg::*;

   localparam int RSP_PAD_W = RSP_DATA_W - AVG_W - RATIO_AVG_W - SAMPLE_W - COUNT_W;

   op_type                 op_ff;
   logic [SAMPLE_W-1:0]    sample_ff;
   logic [VCC_W-1:0]       vcc_ff;

   logic [RAW_SUM_W-1:0]   raw_sum_ff, raw_sum_in;
   logic [RATIO_SUM_W-1:0] ratio_sum_ff, ratio_sum_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [AVG_W-1:0]       held_avg_ff, held_avg_in;
   logic [RATIO_AVG_W-1:0] held_ratio_ff, held_ratio_in;
   logic [SAMPLE_W-1:0]    last_ff, last_in;

   logic [AVG_W-1:0]       out_avg_ff;
   logic [RATIO_AVG_W-1:0] out_ratio_ff;
   logic [SAMPLE_W-1:0]    out_last_ff;
   logic [COUNT_W-1:0]     out_count_ff;
   logic                   out_fresh_ff;

   logic [PROD_W-1:0]      prod;
   logic [DIV_W-1:0]       div_dividend;
   logic [VCC_W-1:0]       div_divisor;
   logic [DIV_W-1:0]       div_quo;
   logic                   div_done;

   logic [RAW_SUM_W-1:0]   raw_term;
   logic [RATIO_SUM_W-1:0] ratio_term;
   logic [RAW_SUM_W-1:0]   raw_add;
   logic [RATIO_SUM_W-1:0] ratio_add;
   logic [COUNT_W-1:0]     count_add;

   assign prod = PROD_W'(sample_ff) * PROD_W'(RAIL_NOMINAL_MV);

   always_comb begin
      unique case (cmd.div_sel)
         DIV_TERM: begin
            div_dividend = DIV_W'(prod) << FRACTION_BITS;
            div_divisor  = vcc_ff;
         end
         DIV_RAW: begin
            div_dividend = DIV_W'(raw_sum_ff);
            div_divisor  = VCC_W'(count_ff);
         end
         DIV_RATIO: begin
            div_dividend = DIV_W'(ratio_sum_ff);
            div_divisor  = VCC_W'(count_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   rmadc_div #(
      .DIV_W(DIV_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .quotient(div_quo),
      .done    (div_done)
   );

   assign raw_term   = RAW_SUM_W'(sample_ff) << FRACTION_BITS;
   // low rail adds the raw term; the quotient is not valid then
   assign ratio_term = status.low_rail ? (RATIO_SUM_W'(sample_ff) << FRACTION_BITS)
                                       : div_quo[RATIO_SUM_W-1:0];
   assign raw_add    = raw_sum_ff + raw_term;
   assign ratio_add  = ratio_sum_ff + ratio_term;
   assign count_add  = count_ff + COUNT_W'(1);

   always_comb begin
      raw_sum_in    = raw_sum_ff;
      ratio_sum_in  = ratio_sum_ff;
      count_in      = count_ff;
      held_avg_in   = held_avg_ff;
      held_ratio_in = held_ratio_ff;
      last_in       = last_ff;
      priority if (cmd.clear) begin
         raw_sum_in    = '0;
         ratio_sum_in  = '0;
         count_in      = '0;
         held_avg_in   = '0;
         held_ratio_in = '0;
         last_in       = '0;
      end else if (cmd.add) begin
         last_in = sample_ff;
         if (count_add == COUNT_W'(HALVING_COUNT)) begin
            raw_sum_in   = raw_add >> 1;
            ratio_sum_in = ratio_add >> 1;
            count_in     = count_add >> 1;
         end else begin
            raw_sum_in   = raw_add;
            ratio_sum_in = ratio_add;
            count_in     = count_add;
         end
      end else if (cmd.store_raw) begin
         held_avg_in = div_quo[AVG_W-1:0];
      end else if (cmd.store_ratio) begin
         held_ratio_in = div_quo[RATIO_AVG_W-1:0];
         raw_sum_in    = '0;
         ratio_sum_in  = '0;
         count_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_sum_ff    <= '0;
         ratio_sum_ff  <= '0;
         count_ff      <= '0;
         held_avg_ff   <= '0;
         held_ratio_ff <= '0;
         last_ff       <= '0;
      end else begin
         raw_sum_ff    <= raw_sum_in;
         ratio_sum_ff  <= ratio_sum_in;
         count_ff      <= count_in;
         held_avg_ff   <= held_avg_in;
         held_ratio_ff <= held_ratio_in;
         last_ff       <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_type'(req_tuser[OP_W-1:0]);
         sample_ff <= req_tdata[SAMPLE_W-1:0];
         vcc_ff    <= req_tdata[SAMPLE_W +: VCC_W];
      end
      // result word is loaded from the state after the update
      if (cmd.emit) begin
         out_avg_ff   <= held_avg_ff;
         out_ratio_ff <= held_ratio_ff;
         out_last_ff  <= last_ff;
         out_count_ff <= count_ff;
         out_fresh_ff <= cmd.fresh;
      end
   end

   assign status.op         = op_ff;
   assign status.low_rail   = (vcc_ff < RAIL_LOW_MV);
   assign status.count_zero = (count_ff == '0);
   assign status.div_done   = div_done;

   assign rsp_tdata = {RSP_PAD_W'(0), out_count_ff, out_last_ff, out_ratio_ff, out_avg_ff};
   assign rsp_tuser = out_fresh_ff;

endmodule

[hw/rtl/rmadc_ctrl.sv]
// Controller state machine: sequences one word at a time and owns rsp_tvalid.
// Depends on rmadc_pkg.
module rmadc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  rmadc_pkg::dp_status_type status,
   output rmadc_pkg::dp_cmd_type    cmd
);
   import rmadc_pkg::*;

   state_type state_ff, state_in;
   logic      fresh_ff, fresh_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      fresh_in    = fresh_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      cmd.div_sel = DIV_TERM;
      cmd.fresh   = fresh_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               fresh_in = 1'b0;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.op)
               OP_ADD: begin
                  if (status.low_rail) begin
                     state_in = ST_ADD;
                  end else begin
                     cmd.div_start = 1'b1;
                     cmd.div_sel   = DIV_TERM;
                     state_in      = ST_DIV_TERM;
                  end
               end
               OP_AVG: begin
                  if (status.count_zero) begin
                     state_in = ST_EMIT;
                  end else begin
                     cmd.div_start = 1'b1;
                     cmd.div_sel   = DIV_RAW;
                     fresh_in      = 1'b1;
                     state_in      = ST_DIV_RAW;
                  end
               end
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_EMIT;
               end
               OP_NONE: begin
                  state_in = ST_EMIT;
               end
               default: begin
                  state_in = ST_EMIT;
               end
            endcase
         end
         ST_DIV_TERM: begin
            if (status.div_done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_DIV_RAW: begin
            cmd.div_sel = DIV_RAW;
            if (status.div_done) begin
               cmd.store_raw = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_RATIO;
               state_in      = ST_DIV_RATIO;
            end
         end
         ST_DIV_RATIO: begin
            cmd.div_sel = DIV_RATIO;
            if (status.div_done) begin
               cmd.store_ratio = 1'b1;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[hw/rtl/ratiometric_adc_averager.sv]
// Ratiometric ADC averager: add sample, take average and clear, one word at a time.
// Add sample does one serial divide, or none below the low-rail threshold; take average
// does two serial divides; clear, the unused operation and an average with no samples
// need no divide. DIV_W is 33 at the default parameters, the larger of the term width
// and the ratio sum width. The result sits in an output register, so the next word is
// taken while it waits. Synchronous active-high reset zeroes all sums, count and held values.
module ratiometric_adc_averager #(
   parameter int FRACTION_BITS = 8,
   parameter int HALVING_COUNT = 254
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [1:0] operation
   input  logic [rmadc_pkg::REQ_USER_W-1:0] req_tuser,
   // [11:0] sample, [24:12] vcc_mv, rest zero
   input  logic [rmadc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] fresh
   output logic [rmadc_pkg::RSP_USER_W-1:0] rsp_tuser,
   // [19:0] avg_value, [40:20] avg_ratiometric, [52:41] latest_sample,
   // [60:53] sample_count, rest zero
   output logic [rmadc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rmadc_pkg::*;

   localparam int TERM_W = SAMPLE_W + VCC_W + FRACTION_BITS;
   localparam int DIV_W  = (TERM_W > RATIO_SUM_W) ? TERM_W : RATIO_SUM_W;

   dp_cmd_type    cmd;
   dp_status_type status;

   rmadc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   rmadc_dp #(
      .FRACTION_BITS(FRACTION_BITS),
      .HALVING_COUNT(HALVING_COUNT),
      .DIV_W        (DIV_W)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata)
   );

endmodule
